// ===== hw/rtl/mamt_pkg.sv =====
// shared types and opcode constants for the matrix add/multiply/transpose unit
package mamt_pkg;

  localparam logic [2:0] OP_LOAD_LEFT  = 3'd0;
  localparam logic [2:0] OP_LOAD_RIGHT = 3'd1;
  localparam logic [2:0] OP_ADD        = 3'd2;
  localparam logic [2:0] OP_MUL        = 3'd3;
  localparam logic [2:0] OP_TRANSPOSE  = 3'd4;

  localparam logic [1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [1:0] REG_LEFT_COLS  = 2'd1;
  localparam logic [1:0] REG_RIGHT_ROWS = 2'd2;
  localparam logic [1:0] REG_RIGHT_COLS = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_ACC
  } state_t;

  typedef enum logic [1:0] {
    RUN_ADD,
    RUN_MUL,
    RUN_TRANSPOSE
  } run_t;

  typedef struct packed {
    logic capture;
    logic accum;
  } ctl_t;

endpackage

// ===== hw/rtl/matrix_add_mul_transpose_unit_top.sv =====
// top level of the matrix add/multiply/transpose unit
//
//  channel   handshake                 moves
//  command   start / busy              opcode, row_index, col_index, elem_value
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//  result    out_valid (strobe only)   out_row, out_col, out_value, last, size_error
//
// a load word is written into its store at the accepting edge and busy stays low.
// add and transpose take one term per result element, multiply takes left_cols terms:
// each term is a store read, one registered multiply, add or copy, then an accumulate.
// a size mismatch gives its error word the cycle after start, with busy staying low.
// reset (rst, synchronous) sets all four dimensions to 1; store contents stay undefined.
// the receiver cannot stall: each result is on the ports for exactly one cycle.
module matrix_add_mul_transpose_unit_top #(
  parameter int MAX_DIM = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] elem_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output logic               out_valid,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               last,
  output logic               size_error
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIM   = (MAX_DIM < 8) ? MAX_DIM : 8;

  mamt_pkg::state_t state, state_next;
  mamt_pkg::run_t   run_op;
  mamt_pkg::ctl_t   ctl;

  logic [3:0] left_rows, left_cols, right_rows, right_cols;
  logic [3:0] lr, lc, rr, rc;
  logic [3:0] nr, nc, nk;
  logic [2:0] r_cnt, c_cnt, k_cnt;
  logic       k_last, el_last;

  logic          accept, load_ok, is_run, run_err;
  logic          l_we, r_we;
  logic [AW-1:0] w_addr, l_raddr, r_raddr;
  logic [31:0]   l_rdata, r_rdata;
  logic [31:0]   mul_low;
  logic [31:0]   prod, acc, acc_sum;

  function automatic logic [3:0] eff_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return 4'd1;
    end
    if (v > 4'(LIM)) begin
      return 4'(LIM);
    end
    return v;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [2:0] row, input logic [2:0] col);
    return AW'(int'(row) * MAX_DIM + int'(col));
  endfunction

  assign busy      = (state != mamt_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign lr = eff_dim(left_rows);
  assign lc = eff_dim(left_cols);
  assign rr = eff_dim(right_rows);
  assign rc = eff_dim(right_cols);

  // opcode decode for the word being accepted
  always_comb begin
    is_run  = 1'b0;
    run_err = 1'b0;
    unique case (opcode)
      mamt_pkg::OP_ADD: begin
        is_run  = 1'b1;
        run_err = (lr != rr) || (lc != rc);
      end
      mamt_pkg::OP_MUL: begin
        is_run  = 1'b1;
        run_err = (lc != rr);
      end
      mamt_pkg::OP_TRANSPOSE: begin
        is_run = 1'b1;
      end
      default: begin
        is_run = 1'b0;
      end
    endcase
  end

  // loads outside the store are dropped
  assign load_ok = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign l_we    = accept && load_ok && (opcode == mamt_pkg::OP_LOAD_LEFT);
  assign r_we    = accept && load_ok && (opcode == mamt_pkg::OP_LOAD_RIGHT);
  assign w_addr  = addr_of(row_index, col_index);

  always_comb begin
    l_raddr = addr_of(r_cnt, c_cnt);
    r_raddr = addr_of(r_cnt, c_cnt);
    case (run_op)
      mamt_pkg::RUN_MUL: begin
        l_raddr = addr_of(r_cnt, k_cnt);
        r_raddr = addr_of(k_cnt, c_cnt);
      end
      mamt_pkg::RUN_TRANSPOSE: begin
        l_raddr = addr_of(c_cnt, r_cnt);
      end
      default: begin
        l_raddr = addr_of(r_cnt, c_cnt);
      end
    endcase
  end

  mamt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (w_addr),
    .wdata (elem_value),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  mamt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (w_addr),
    .wdata (elem_value),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  assign k_last   = ({1'b0, k_cnt} == nk - 4'd1);
  assign el_last  = ({1'b0, r_cnt} == nr - 4'd1) && ({1'b0, c_cnt} == nc - 4'd1);
  // only the low word of the product is kept, results wrap at 32 bits
  assign mul_low  = l_rdata * r_rdata;
  assign acc_sum  = ((k_cnt == 3'd0) ? 32'd0 : acc) + prod;

  always_comb begin
    state_next = state;
    unique case (state)
      mamt_pkg::S_IDLE: begin
        if (accept && is_run && !run_err) begin
          state_next = mamt_pkg::S_ADDR;
        end
      end
      mamt_pkg::S_ADDR: state_next = mamt_pkg::S_DATA;
      mamt_pkg::S_DATA: state_next = mamt_pkg::S_ACC;
      mamt_pkg::S_ACC: begin
        state_next = (k_last && el_last) ? mamt_pkg::S_IDLE : mamt_pkg::S_ADDR;
      end
      default: state_next = mamt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      mamt_pkg::S_DATA: ctl.capture = 1'b1;
      mamt_pkg::S_ACC:  ctl.accum   = 1'b1;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mamt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      left_rows  <= 4'd1;
      left_cols  <= 4'd1;
      right_rows <= 4'd1;
      right_cols <= 4'd1;
    end else begin
      out_valid <= (accept && is_run && run_err) || (ctl.accum && k_last);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mamt_pkg::REG_LEFT_ROWS:  left_rows  <= cfg_data;
          mamt_pkg::REG_LEFT_COLS:  left_cols  <= cfg_data;
          mamt_pkg::REG_RIGHT_ROWS: right_rows <= cfg_data;
          mamt_pkg::REG_RIGHT_COLS: right_cols <= cfg_data;
          default: left_rows <= left_rows;
        endcase
      end
    end
  end

  // run datapath and result word
  always_ff @(posedge clk) begin
    if (accept && is_run) begin
      r_cnt <= 3'd0;
      c_cnt <= 3'd0;
      k_cnt <= 3'd0;
      unique case (opcode)
        mamt_pkg::OP_ADD: begin
          run_op <= mamt_pkg::RUN_ADD;
          nr     <= lr;
          nc     <= lc;
          nk     <= 4'd1;
        end
        mamt_pkg::OP_MUL: begin
          run_op <= mamt_pkg::RUN_MUL;
          nr     <= lr;
          nc     <= rc;
          nk     <= lc;
        end
        default: begin
          run_op <= mamt_pkg::RUN_TRANSPOSE;
          nr     <= lc;
          nc     <= lr;
          nk     <= 4'd1;
        end
      endcase
      if (run_err) begin
        out_row    <= 3'd0;
        out_col    <= 3'd0;
        out_value  <= '0;
        last       <= 1'b1;
        size_error <= 1'b1;
      end
    end
    if (ctl.capture) begin
      case (run_op)
        mamt_pkg::RUN_ADD: prod <= l_rdata + r_rdata;
        mamt_pkg::RUN_MUL: prod <= mul_low;
        default:           prod <= l_rdata;
      endcase
    end
    if (ctl.accum) begin
      acc <= acc_sum;
      if (k_last) begin
        out_row    <= r_cnt;
        out_col    <= c_cnt;
        out_value  <= acc_sum;
        last       <= el_last;
        size_error <= 1'b0;
        k_cnt      <= 3'd0;
        if ({1'b0, c_cnt} == nc - 4'd1) begin
          c_cnt <= 3'd0;
          r_cnt <= r_cnt + 3'd1;
        end else begin
          c_cnt <= c_cnt + 3'd1;
        end
      end else begin
        k_cnt <= k_cnt + 3'd1;
      end
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && size_error |-> last)
    else $error("error word without last");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> state == mamt_pkg::S_IDLE)
    else $error("run still busy after its last word");

  a_acc_after_data: assert property (@(posedge clk) disable iff (rst)
    state == mamt_pkg::S_ACC |-> $past(state) == mamt_pkg::S_DATA)
    else $error("accumulate without captured read data");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    state != mamt_pkg::S_IDLE |-> {1'b0, k_cnt} < nk)
    else $error("term counter past inner dimension");

  a_word_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> !out_valid)
    else $error("result words closer than a term cycle");

endmodule

// ===== hw/rtl/mamt_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module mamt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
